/* hw/rtl/fppu_pkg.sv */
// shared types, constants and colour ramp tables for the particle update block
// no dependencies; imported by every module of the block
package fppu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // particle kinds
    localparam logic [2:0] KIND_STATIC   = 3'd0;
    localparam logic [2:0] KIND_GRAV     = 3'd1;
    localparam logic [2:0] KIND_SLOWGRAV = 3'd2;
    localparam logic [2:0] KIND_FIRE     = 3'd3;
    localparam logic [2:0] KIND_EXPLODE  = 3'd4;
    localparam logic [2:0] KIND_EXPLODE2 = 3'd5;
    localparam logic [2:0] KIND_BLOB     = 3'd6;
    localparam logic [2:0] KIND_BLOB2    = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_STEP     = 3'd0;
    localparam logic [2:0] REG_FIRE_RAMP_STEP = 3'd1;
    localparam logic [2:0] REG_EXPL_RAMP_STEP = 3'd2;
    localparam logic [2:0] REG_EXPL2_RAMP_STEP = 3'd3;
    localparam logic [2:0] REG_GRAVITY_STEP   = 3'd4;
    localparam logic [2:0] REG_DRAG_STEP      = 3'd5;

    // ramp end points, 8 fractional bits
    localparam logic [31:0] FIRE_RAMP_END    = 32'(6 << 8);
    localparam logic [31:0] EXPLODE_RAMP_END = 32'(8 << 8);

    typedef enum logic [1:0] {
        VOP_NONE = 2'b00,
        VOP_ADD  = 2'b01,
        VOP_SUB  = 2'b10
    } vel_op_t;

    typedef enum logic [1:0] {
        GOP_NONE = 2'b00,
        GOP_ADD  = 2'b01,
        GOP_SUB  = 2'b10
    } grav_op_t;

    typedef struct packed {
        logic [15:0] frame_step;
        logic [15:0] fire_ramp_step;
        logic [15:0] explode_ramp_step;
        logic [15:0] explode2_ramp_step;
        logic [15:0] gravity_step;
        logic [15:0] drag_step;
    } cfg_t;

    // what the back end has to do with one record
    typedef struct packed {
        logic     alive;
        logic     use_frame;
        vel_op_t  vop_x;
        vel_op_t  vop_y;
        vel_op_t  vop_z;
        grav_op_t gop;
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        ramp;
        logic signed [31:0] life;
        logic [7:0]         colour;
    } item_t;

    function automatic logic [7:0] explode_colour(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6f;
            3'd1:    c = 8'h6d;
            3'd2:    c = 8'h6b;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h67;
            3'd5:    c = 8'h65;
            3'd6:    c = 8'h63;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] explode2_colour(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6f;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h6d;
            3'd3:    c = 8'h6c;
            3'd4:    c = 8'h6b;
            3'd5:    c = 8'h6a;
            3'd6:    c = 8'h68;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fire_colour(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6d;
            3'd1:    c = 8'h6b;
            3'd2:    c = 8'h06;
            3'd3:    c = 8'h05;
            3'd4:    c = 8'h04;
            3'd5:    c = 8'h03;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/fppu_front.sv */
// front end: takes one particle record, ages it, runs the colour ramp and
// decodes its kind into back-end operations; uses fppu_pkg
module fppu_front (
    input  fppu_pkg::cfg_t      cfg,
    input  logic [2:0]          kind,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  vel_z,
    input  logic [30:0]         ramp_in,
    input  logic signed [31:0]  life_in,
    input  logic [7:0]          colour_in,
    output fppu_pkg::item_t     item
);
    import fppu_pkg::*;

    logic [31:0] life_dec;
    logic        alive;
    logic [15:0] ramp_step;
    logic        has_ramp;
    logic [31:0] ramp_sum;
    logic [31:0] ramp_end;
    logic        ramp_done;
    logic [7:0]  ramp_colour;
    op_t         op;

    // life drops first; a negative result removes the particle
    assign life_dec = life_in - {16'd0, cfg.frame_step};
    assign alive    = ~life_dec[31];

    // ramp step and end point by kind
    always_comb
    begin
        ramp_step = 16'd0;
        has_ramp  = 1'b0;
        ramp_end  = EXPLODE_RAMP_END;
        case (kind)
            KIND_FIRE:
            begin
                ramp_step = cfg.fire_ramp_step;
                has_ramp  = 1'b1;
                ramp_end  = FIRE_RAMP_END;
            end
            KIND_EXPLODE:
            begin
                ramp_step = cfg.explode_ramp_step;
                has_ramp  = 1'b1;
            end
            KIND_EXPLODE2:
            begin
                ramp_step = cfg.explode2_ramp_step;
                has_ramp  = 1'b1;
            end
            default:
            begin
                ramp_step = 16'd0;
                has_ramp  = 1'b0;
            end
        endcase
    end

    assign ramp_sum  = {1'b0, ramp_in} + {16'd0, ramp_step};
    assign ramp_done = (ramp_sum >= ramp_end);

    // colour lookup on the ramp's integer part
    always_comb
    begin
        case (kind)
            KIND_FIRE:     ramp_colour = fire_colour(ramp_sum[10:8]);
            KIND_EXPLODE:  ramp_colour = explode_colour(ramp_sum[10:8]);
            KIND_EXPLODE2: ramp_colour = explode2_colour(ramp_sum[10:8]);
            default:       ramp_colour = colour_in;
        endcase
    end

    // velocity and gravity operations by kind
    always_comb
    begin
        op.alive     = alive;
        op.use_frame = 1'b0;
        op.vop_x     = VOP_NONE;
        op.vop_y     = VOP_NONE;
        op.vop_z     = VOP_NONE;
        op.gop       = GOP_NONE;
        if (alive)
        begin
            case (kind)
                KIND_GRAV, KIND_SLOWGRAV:
                begin
                    op.gop = GOP_SUB;
                end
                KIND_FIRE:
                begin
                    op.gop = GOP_ADD;
                end
                KIND_EXPLODE, KIND_BLOB:
                begin
                    op.vop_x = VOP_ADD;
                    op.vop_y = VOP_ADD;
                    op.vop_z = VOP_ADD;
                    op.gop   = GOP_SUB;
                end
                KIND_EXPLODE2:
                begin
                    op.use_frame = 1'b1;
                    op.vop_x     = VOP_SUB;
                    op.vop_y     = VOP_SUB;
                    op.vop_z     = VOP_SUB;
                    op.gop       = GOP_SUB;
                end
                KIND_BLOB2:
                begin
                    op.vop_x = VOP_SUB;
                    op.vop_y = VOP_SUB;
                    op.gop   = GOP_SUB;
                end
                default:
                begin
                    op.gop = GOP_NONE;
                end
            endcase
        end
    end

    // record handed to the queue
    always_comb
    begin
        item.op     = op;
        item.pos_x  = pos_x;
        item.pos_y  = pos_y;
        item.pos_z  = pos_z;
        item.vel_x  = vel_x;
        item.vel_y  = vel_y;
        item.vel_z  = vel_z;
        item.ramp   = ramp_in;
        item.life   = life_dec;
        item.colour = colour_in;
        if (alive && has_ramp)
        begin
            item.ramp = ramp_sum[30:0];
            if (ramp_done)
            begin
                item.life = '1;
            end
            else
            begin
                item.colour = ramp_colour;
            end
        end
    end

endmodule

/* hw/rtl/fppu_queue.sv */
// short record queue between front and back end
// uses fppu_pkg for the record type and depth
module fppu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fppu_pkg::item_t push_item,
    input  logic            pop,
    output fppu_pkg::item_t head_item,
    output logic            empty,
    output logic            full
);
    import fppu_pkg::*;

    item_t                 mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QPTR_W:0]       count_reg;
    logic [QPTR_W:0]       count_next;
    logic                  do_push;
    logic                  do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign head_item = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/fppu_back.sv */
// back end: two-stage pipeline, products then shifts, sums and gravity
// uses fppu_pkg; never stalls
module fppu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  fppu_pkg::cfg_t     cfg,
    input  logic               in_valid,
    input  fppu_pkg::item_t    in_item,
    output logic               done,
    output logic               alive,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic [30:0]        ramp_out,
    output logic signed [31:0] life_out,
    output logic [7:0]         colour_out
);
    import fppu_pkg::*;

    logic               mul_valid_reg;
    item_t              mul_item_reg;
    logic signed [48:0] mot_prod_reg [3];
    logic signed [48:0] vel_prod_reg [3];
    logic signed [48:0] mot_prod_next [3];
    logic signed [48:0] vel_prod_next [3];
    logic signed [16:0] frame_f;
    logic signed [16:0] vel_f;

    logic               done_reg;
    item_t              out_reg;
    item_t              out_next;

    logic signed [31:0] vel_in [3];
    logic signed [31:0] pos_in [3];
    logic signed [31:0] pos_new [3];
    logic signed [31:0] vel_new [3];
    logic signed [48:0] mot_sh [3];
    logic signed [48:0] vel_sh [3];
    vel_op_t            vop [3];

    assign frame_f = $signed({1'b0, cfg.frame_step});
    assign vel_f   = $signed({1'b0, in_item.op.use_frame ? cfg.frame_step : cfg.drag_step});

    // stage 1: motion and velocity products per axis
    always_comb
    begin
        mot_prod_next[0] = 49'(in_item.vel_x) * 49'(frame_f);
        mot_prod_next[1] = 49'(in_item.vel_y) * 49'(frame_f);
        mot_prod_next[2] = 49'(in_item.vel_z) * 49'(frame_f);
        vel_prod_next[0] = 49'(in_item.vel_x) * 49'(vel_f);
        vel_prod_next[1] = 49'(in_item.vel_y) * 49'(vel_f);
        vel_prod_next[2] = 49'(in_item.vel_z) * 49'(vel_f);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_item_reg <= in_item;
        for (int i = 0; i < 3; i++)
        begin
            mot_prod_reg[i] <= mot_prod_next[i];
            vel_prod_reg[i] <= vel_prod_next[i];
        end
    end

    // stage 2: floor shifts, wrapping sums, gravity
    always_comb
    begin
        pos_in[0] = mul_item_reg.pos_x;
        pos_in[1] = mul_item_reg.pos_y;
        pos_in[2] = mul_item_reg.pos_z;
        vel_in[0] = mul_item_reg.vel_x;
        vel_in[1] = mul_item_reg.vel_y;
        vel_in[2] = mul_item_reg.vel_z;
        vop[0]    = mul_item_reg.op.vop_x;
        vop[1]    = mul_item_reg.op.vop_y;
        vop[2]    = mul_item_reg.op.vop_z;
        for (int i = 0; i < 3; i++)
        begin
            mot_sh[i] = mot_prod_reg[i] >>> 9;
            vel_sh[i] = mul_item_reg.op.use_frame ? (vel_prod_reg[i] >>> 9)
                                                  : (vel_prod_reg[i] >>> 8);
            pos_new[i] = mul_item_reg.op.alive ? pos_in[i] + mot_sh[i][31:0] : pos_in[i];
            case (vop[i])
                VOP_ADD: vel_new[i] = vel_in[i] + vel_sh[i][31:0];
                VOP_SUB: vel_new[i] = vel_in[i] - vel_sh[i][31:0];
                default: vel_new[i] = vel_in[i];
            endcase
        end
        case (mul_item_reg.op.gop)
            GOP_ADD: vel_new[2] = vel_new[2] + {16'd0, cfg.gravity_step};
            GOP_SUB: vel_new[2] = vel_new[2] - {16'd0, cfg.gravity_step};
            default: vel_new[2] = vel_new[2];
        endcase

        out_next       = mul_item_reg;
        out_next.pos_x = pos_new[0];
        out_next.pos_y = pos_new[1];
        out_next.pos_z = pos_new[2];
        out_next.vel_x = vel_new[0];
        out_next.vel_y = vel_new[1];
        out_next.vel_z = vel_new[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // result beat
    assign done       = done_reg;
    assign alive      = out_reg.op.alive;
    assign new_pos_x  = out_reg.pos_x;
    assign new_pos_y  = out_reg.pos_y;
    assign new_pos_z  = out_reg.pos_z;
    assign new_vel_x  = out_reg.vel_x;
    assign new_vel_y  = out_reg.vel_y;
    assign new_vel_z  = out_reg.vel_z;
    assign ramp_out   = out_reg.ramp;
    assign life_out   = out_reg.life;
    assign colour_out = out_reg.colour;

endmodule

/* hw/rtl/fixed_point_particle_update.sv */
// particle update top level: config registers, front end, queue, back end
// a record passes the queue, product and output registers before its done beat
// throughput: one record per cycle; the back end never stalls, so the queue
// drains as fast as it fills and busy stays low in practice
// reset: all config registers clear to zero, queue and pipeline empty
// depends on fppu_pkg, fppu_front, fppu_queue, fppu_back
module fixed_point_particle_update (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [30:0]        ramp_in,
    input  logic signed [31:0] life_in,
    input  logic [7:0]         colour_in,
    output logic               done,
    output logic               alive,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic [30:0]        ramp_out,
    output logic signed [31:0] life_out,
    output logic [7:0]         colour_out
);
    import fppu_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    item_t front_item;
    item_t head_item;
    logic  q_empty;
    logic  q_full;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !q_full;

    // config register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_STEP:      cfg_next.frame_step         = cfg_data;
                REG_FIRE_RAMP_STEP:  cfg_next.fire_ramp_step     = cfg_data;
                REG_EXPL_RAMP_STEP:  cfg_next.explode_ramp_step  = cfg_data;
                REG_EXPL2_RAMP_STEP: cfg_next.explode2_ramp_step = cfg_data;
                REG_GRAVITY_STEP:    cfg_next.gravity_step       = cfg_data;
                REG_DRAG_STEP:       cfg_next.drag_step          = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    fppu_front u_front (
        .cfg       (cfg_reg),
        .kind      (kind),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .ramp_in   (ramp_in),
        .life_in   (life_in),
        .colour_in (colour_in),
        .item      (front_item)
    );

    // record queue
    fppu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (!q_empty),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back end
    fppu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (!q_empty),
        .in_item    (head_item),
        .done       (done),
        .alive      (alive),
        .new_pos_x  (new_pos_x),
        .new_pos_y  (new_pos_y),
        .new_pos_z  (new_pos_z),
        .new_vel_x  (new_vel_x),
        .new_vel_y  (new_vel_y),
        .new_vel_z  (new_vel_z),
        .ramp_out   (ramp_out),
        .life_out   (life_out),
        .colour_out (colour_out)
    );

endmodule

/* dv/testbench.sv */
// self-checking testbench for the fixed-point particle update block
// depends on fppu_pkg and the fixed_point_particle_update top level; no files or arguments
// directed table first, then random records over several register settings, checked per field
`timescale 1ns / 1ps

module testbench;
    import fppu_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [31:0] S32_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [30:0] RAMP_MAX = 31'h7fff_ffff;

    // colour ramps, entry i in byte i
    localparam logic [63:0] EXPLODE_COLOURS  = 64'h6163_6567_696b_6d6f;
    localparam logic [63:0] EXPLODE2_COLOURS = 64'h6668_6a6b_6c6d_6e6f;
    localparam logic [63:0] FIRE_COLOURS     = 64'h0000_0304_0506_6b6d;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        ramp;
        logic signed [31:0] life;
        logic [7:0]         colour;
    } stim_rec_t;

    typedef struct packed {
        logic               alive;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        ramp;
        logic signed [31:0] life;
        logic [7:0]         colour;
    } update_t;

    // directed row: typed rows carry alive, life and colour; all other fields pass through
    typedef struct {
        stim_rec_t  stim;
        bit         typed;
        logic       alive;
        logic [31:0] life;
        logic [7:0] colour;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               start;
    logic               busy;
    logic [2:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        ramp_in;
    logic signed [31:0] life_in;
    logic [7:0]         colour_in;
    logic               done;
    logic               alive;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [30:0]        ramp_out;
    logic signed [31:0] life_out;
    logic [7:0]         colour_out;

    cfg_t        step_regs;
    update_t     pending_updates[$];
    dir_row_t    dir_rows[$];
    int unsigned mismatches;
    int unsigned cycles;

    fixed_point_particle_update DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .ramp_in    (ramp_in),
        .life_in    (life_in),
        .colour_in  (colour_in),
        .done       (done),
        .alive      (alive),
        .new_pos_x  (new_pos_x),
        .new_pos_y  (new_pos_y),
        .new_pos_z  (new_pos_z),
        .new_vel_x  (new_vel_x),
        .new_vel_y  (new_vel_y),
        .new_vel_z  (new_vel_z),
        .ramp_out   (ramp_out),
        .life_out   (life_out),
        .colour_out (colour_out)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d updates outstanding",
                     cycles, pending_updates.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // signed value times unsigned step, floored shift, low 32 bits kept
    function automatic logic [31:0] scaled_by_step(input logic signed [31:0] v,
                                                   input logic [15:0] f, input int sh);
        longint prod;
        prod = longint'(v) * longint'(f);
        prod = prod >>> sh;
        return prod[31:0];
    endfunction

    // one frame of particle physics under the current step registers
    function automatic update_t advance_particle(input stim_rec_t p);
        logic [31:0] pos[3];
        logic [31:0] vel[3];
        logic [31:0] ramp;
        logic [31:0] life;
        logic [7:0]  colour;
        update_t     r;
        pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
        vel[0] = p.vel_x; vel[1] = p.vel_y; vel[2] = p.vel_z;
        ramp   = {1'b0, p.ramp};
        colour = p.colour;
        life   = p.life - {16'd0, step_regs.frame_step};
        r.alive = ~life[31];
        if (r.alive)
        begin
            for (int i = 0; i < 3; i++)
                pos[i] = pos[i] + scaled_by_step(vel[i], step_regs.frame_step, 9);
            case (p.kind)
                KIND_GRAV, KIND_SLOWGRAV:
                    vel[2] = vel[2] - {16'd0, step_regs.gravity_step};
                KIND_FIRE:
                begin
                    ramp = ramp + {16'd0, step_regs.fire_ramp_step};
                    if (ramp >= FIRE_RAMP_END)
                        life = ALL_ONES;
                    else
                        colour = FIRE_COLOURS[8 * ramp[10:8] +: 8];
                    vel[2] = vel[2] + {16'd0, step_regs.gravity_step};
                end
                KIND_EXPLODE:
                begin
                    ramp = ramp + {16'd0, step_regs.explode_ramp_step};
                    if (ramp >= EXPLODE_RAMP_END)
                        life = ALL_ONES;
                    else
                        colour = EXPLODE_COLOURS[8 * ramp[10:8] +: 8];
                    for (int i = 0; i < 3; i++)
                        vel[i] = vel[i] + scaled_by_step(vel[i], step_regs.drag_step, 8);
                    vel[2] = vel[2] - {16'd0, step_regs.gravity_step};
                end
                KIND_EXPLODE2:
                begin
                    ramp = ramp + {16'd0, step_regs.explode2_ramp_step};
                    if (ramp >= EXPLODE_RAMP_END)
                        life = ALL_ONES;
                    else
                        colour = EXPLODE2_COLOURS[8 * ramp[10:8] +: 8];
                    for (int i = 0; i < 3; i++)
                        vel[i] = vel[i] - scaled_by_step(vel[i], step_regs.frame_step, 9);
                    vel[2] = vel[2] - {16'd0, step_regs.gravity_step};
                end
                KIND_BLOB:
                begin
                    for (int i = 0; i < 3; i++)
                        vel[i] = vel[i] + scaled_by_step(vel[i], step_regs.drag_step, 8);
                    vel[2] = vel[2] - {16'd0, step_regs.gravity_step};
                end
                KIND_BLOB2:
                begin
                    for (int i = 0; i < 2; i++)
                        vel[i] = vel[i] - scaled_by_step(vel[i], step_regs.drag_step, 8);
                    vel[2] = vel[2] - {16'd0, step_regs.gravity_step};
                end
                default:
                begin
                end
            endcase
        end
        r.pos_x  = pos[0]; r.pos_y = pos[1]; r.pos_z = pos[2];
        r.vel_x  = vel[0]; r.vel_y = vel[1]; r.vel_z = vel[2];
        r.ramp   = ramp[30:0];
        r.life   = life;
        r.colour = colour;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // result beats: one per done strobe, matched against the oldest update
    always @(posedge clk)
    begin
        update_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_updates.size() == 0)
                report_mismatch("result beat with no update outstanding");
            else
            begin
                want = pending_updates.pop_front();
                check_field("alive",      {31'd0, alive},      {31'd0, want.alive});
                check_field("new_pos_x",  new_pos_x,           want.pos_x);
                check_field("new_pos_y",  new_pos_y,           want.pos_y);
                check_field("new_pos_z",  new_pos_z,           want.pos_z);
                check_field("new_vel_x",  new_vel_x,           want.vel_x);
                check_field("new_vel_y",  new_vel_y,           want.vel_y);
                check_field("new_vel_z",  new_vel_z,           want.vel_z);
                check_field("ramp_out",   {1'b0, ramp_out},    {1'b0, want.ramp});
                check_field("life_out",   life_out,            want.life);
                check_field("colour_out", {24'd0, colour_out}, {24'd0, want.colour});
            end
        end
    end

    function automatic stim_rec_t mk_particle(input logic [2:0] k,
        input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
        input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
        input logic [30:0] ramp, input logic [31:0] life, input logic [7:0] colour);
        stim_rec_t p;
        p.kind  = k;
        p.pos_x = px; p.pos_y = py; p.pos_z = pz;
        p.vel_x = vx; p.vel_y = vy; p.vel_z = vz;
        p.ramp  = ramp;
        p.life  = life;
        p.colour = colour;
        return p;
    endfunction

    task automatic add_row(input stim_rec_t p, input bit typed, input logic ealive,
                           input logic [31:0] elife, input logic [7:0] ecolour);
        dir_row_t row;
        row.stim   = p;
        row.typed  = typed;
        row.alive  = ealive;
        row.life   = elife;
        row.colour = ecolour;
        dir_rows.push_back(row);
    endtask

    // mix of extremes, small signed values and full-range noise
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0:       w = 32'd0;
            1:       w = S32_MAX;
            2:       w = S32_MIN;
            3:       w = ALL_ONES;
            4:       w = $urandom_range(0, 8191) - 4096;
            5:       w = $urandom_range(0, 1 << 20) - (1 << 19);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] pick_step();
        logic [15:0] s;
        case ($urandom_range(0, 4))
            0:       s = 16'd0;
            1:       s = 16'hffff;
            2:       s = 16'($urandom_range(1, 64));
            3:       s = 16'($urandom_range(1, 1024));
            default: s = 16'($urandom);
        endcase
        return s;
    endfunction

    // live record with a ramp near the table range, or noise on every field
    function automatic stim_rec_t pick_particle(input bit well_formed);
        stim_rec_t p;
        logic [31:0] fs;
        fs = {16'd0, step_regs.frame_step};
        p = mk_particle(3'($urandom_range(0, 7)), pick_word(), pick_word(), pick_word(),
                        pick_word(), pick_word(), pick_word(), 31'd0, 32'd0, 8'($urandom));
        if (well_formed)
        begin
            p.ramp = 31'($urandom_range(0, 9 * 256));
            case ($urandom_range(0, 5))
                0:       p.life = fs + $urandom_range(0, 3);
                1:       p.life = S32_MAX - $urandom_range(0, 3);
                default: p.life = fs + $urandom_range(0, 1 << 22);
            endcase
        end
        else
        begin
            p.ramp = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4096));
            case ($urandom_range(0, 3))
                0:       p.life = fs - 1;
                1:       p.life = S32_MIN + $urandom_range(0, 3);
                default: p.life = pick_word();
            endcase
        end
        return p;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_FRAME_STEP:      step_regs.frame_step         = data;
            REG_FIRE_RAMP_STEP:  step_regs.fire_ramp_step     = data;
            REG_EXPL_RAMP_STEP:  step_regs.explode_ramp_step  = data;
            REG_EXPL2_RAMP_STEP: step_regs.explode2_ramp_step = data;
            REG_GRAVITY_STEP:    step_regs.gravity_step       = data;
            REG_DRAG_STEP:       step_regs.drag_step          = data;
            default:
            begin
            end
        endcase
    endtask

    task automatic program_steps(input cfg_t c);
        write_reg(REG_FRAME_STEP,      c.frame_step);
        write_reg(REG_FIRE_RAMP_STEP,  c.fire_ramp_step);
        write_reg(REG_EXPL_RAMP_STEP,  c.explode_ramp_step);
        write_reg(REG_EXPL2_RAMP_STEP, c.explode2_ramp_step);
        write_reg(REG_GRAVITY_STEP,    c.gravity_step);
        write_reg(REG_DRAG_STEP,       c.drag_step);
        cfg_valid <= 1'b0;
    endtask

    // one record beat; returns at the edge that accepts it with start still high
    task automatic send_particle(input stim_rec_t p, input update_t want);
        start     <= 1'b1;
        kind      <= p.kind;
        pos_x     <= p.pos_x;
        pos_y     <= p.pos_y;
        pos_z     <= p.pos_z;
        vel_x     <= p.vel_x;
        vel_y     <= p.vel_y;
        vel_z     <= p.vel_z;
        ramp_in   <= p.ramp;
        life_in   <= p.life;
        colour_in <= p.colour;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_updates.push_back(want);
    endtask

    task automatic sender_pause(input bit calm);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // stop sending and let every outstanding update come back
    task automatic drain_updates();
        start <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int        first_cfg_row;
        bit        calm;
        cfg_t      c;
        update_t   want;
        stim_rec_t p;

        mismatches = 0;
        cycles     = 0;
        step_regs  = '0;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_FRAME_STEP;
        cfg_data   <= 16'd0;
        start      <= 1'b0;
        kind       <= KIND_STATIC;
        pos_x      <= 32'd0;
        pos_y      <= 32'd0;
        pos_z      <= 32'd0;
        vel_x      <= 32'd0;
        vel_y      <= 32'd0;
        vel_z      <= 32'd0;
        ramp_in    <= 31'd0;
        life_in    <= 32'd0;
        colour_in  <= 8'd0;

        // all steps at reset zero: only life, colour and the ramp tables act
        add_row(mk_particle(KIND_STATIC, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                            RAMP_MAX, S32_MAX, 8'hff), 1'b1, 1'b1, S32_MAX, 8'hff);
        add_row(mk_particle(KIND_STATIC, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                            31'd0, 32'd0, 8'h00), 1'b1, 1'b1, 32'd0, 8'h00);
        // removed particle: every field passes through
        add_row(mk_particle(KIND_GRAV, 32'd100, -32'sd5, 32'd7, 32'd1, 32'd2, 32'd3,
                            31'd40, ALL_ONES, 8'h5a), 1'b1, 1'b0, ALL_ONES, 8'h5a);
        add_row(mk_particle(KIND_BLOB, ALL_ONES, 32'd1, S32_MAX, S32_MIN, ALL_ONES, 32'd9,
                            RAMP_MAX, S32_MIN, 8'h81), 1'b1, 1'b0, S32_MIN, 8'h81);
        // colour tables at their ends
        add_row(mk_particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            31'd0, 32'd100, 8'h11), 1'b1, 1'b1, 32'd100, 8'h6d);
        add_row(mk_particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            31'h5ff, 32'd100, 8'h11), 1'b1, 1'b1, 32'd100, 8'h03);
        // ramp run out (life -1, colour kept), mixed with more colour table ends
        add_row(mk_particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            31'h600, 32'd100, 8'h11), 1'b1, 1'b1, ALL_ONES, 8'h11);
        add_row(mk_particle(KIND_EXPLODE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            31'h7ff, 32'd100, 8'h22), 1'b1, 1'b1, 32'd100, 8'h61);
        add_row(mk_particle(KIND_EXPLODE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            31'h800, 32'd100, 8'h22), 1'b1, 1'b1, ALL_ONES, 8'h22);
        add_row(mk_particle(KIND_EXPLODE2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            31'd0, 32'd100, 8'h33), 1'b1, 1'b1, 32'd100, 8'h6f);
        add_row(mk_particle(KIND_EXPLODE2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            31'h700, 32'd100, 8'h33), 1'b1, 1'b1, 32'd100, 8'h66);
        add_row(mk_particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                            RAMP_MAX, 32'd100, 8'h44), 1'b1, 1'b1, ALL_ONES, 8'h44);

        // steps at their extremes from here, checked by the predictor
        first_cfg_row = dir_rows.size();
        add_row(mk_particle(KIND_STATIC, 32'd0, S32_MAX, S32_MIN, S32_MAX, S32_MIN, ALL_ONES,
                            31'd0, S32_MAX, 8'h01), 1'b0, 1'b0, 32'd0, 8'h00);
        add_row(mk_particle(KIND_GRAV, 32'd5, 32'd6, 32'd7, 32'd0, 32'd0, S32_MIN,
                            31'd0, S32_MAX, 8'h02), 1'b0, 1'b0, 32'd0, 8'h00);
        add_row(mk_particle(KIND_SLOWGRAV, ALL_ONES, ALL_ONES, ALL_ONES, 32'd256, -32'sd256,
                            32'd1, 31'd0, 32'd70000, 8'h03), 1'b0, 1'b0, 32'd0, 8'h00);
        // ramp sum beyond 31 bits is truncated on the way out
        add_row(mk_particle(KIND_FIRE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, S32_MAX,
                            RAMP_MAX, S32_MAX, 8'h04), 1'b0, 1'b0, 32'd0, 8'h00);
        add_row(mk_particle(KIND_EXPLODE, 32'd0, 32'd0, 32'd0, S32_MAX, S32_MIN, ALL_ONES,
                            31'd0, S32_MAX, 8'h05), 1'b0, 1'b0, 32'd0, 8'h00);
        add_row(mk_particle(KIND_EXPLODE2, 32'd0, 32'd0, 32'd0, S32_MIN, S32_MAX, 32'd1000,
                            31'd0, S32_MAX, 8'h06), 1'b0, 1'b0, 32'd0, 8'h00);
        add_row(mk_particle(KIND_BLOB, 32'd0, 32'd0, 32'd0, S32_MAX, S32_MAX, S32_MAX,
                            31'd0, S32_MAX, 8'h07), 1'b0, 1'b0, 32'd0, 8'h00);
        add_row(mk_particle(KIND_BLOB2, 32'd0, 32'd0, 32'd0, S32_MIN, S32_MIN, S32_MIN,
                            31'd0, S32_MAX, 8'h08), 1'b0, 1'b0, 32'd0, 8'h00);
        // life overflow: most negative life minus the step wraps positive
        add_row(mk_particle(KIND_GRAV, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6,
                            31'd0, S32_MIN, 8'h09), 1'b0, 1'b0, 32'd0, 8'h00);
        // life exactly spent, and one short of it
        add_row(mk_particle(KIND_BLOB, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6,
                            31'd0, 32'd65535, 8'h0a), 1'b0, 1'b0, 32'd0, 8'h00);
        add_row(mk_particle(KIND_BLOB, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6,
                            31'd0, 32'd65534, 8'h0b), 1'b0, 1'b0, 32'd0, 8'h00);

        // reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table
        for (int i = 0; i < dir_rows.size(); i++)
        begin
            if (i == first_cfg_row)
            begin
                drain_updates();
                c = '1;
                c.explode_ramp_step = 16'd300;
                program_steps(c);
            end
            p = dir_rows[i].stim;
            if (dir_rows[i].typed)
            begin
                want.alive  = dir_rows[i].alive;
                want.pos_x  = p.pos_x; want.pos_y = p.pos_y; want.pos_z = p.pos_z;
                want.vel_x  = p.vel_x; want.vel_y = p.vel_y; want.vel_z = p.vel_z;
                want.ramp   = p.ramp;
                want.life   = dir_rows[i].life;
                want.colour = dir_rows[i].colour;
            end
            else
                want = advance_particle(p);
            send_particle(p, want);
            sender_pause(1'b0);
        end

        // random records over several step settings
        calm = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_updates();
            case (ph)
                0: c = '0;
                1: c = '1;
                2:
                begin
                    c.frame_step         = 16'($urandom_range(4, 20));
                    c.fire_ramp_step     = 16'($urandom_range(20, 200));
                    c.explode_ramp_step  = 16'($urandom_range(20, 200));
                    c.explode2_ramp_step = 16'($urandom_range(20, 200));
                    c.gravity_step       = 16'($urandom_range(1, 40));
                    c.drag_step          = 16'($urandom_range(0, 64));
                end
                default:
                begin
                    c.frame_step         = ($urandom_range(0, 2) == 0) ? pick_step()
                                               : 16'($urandom_range(1, 600));
                    c.fire_ramp_step     = pick_step();
                    c.explode_ramp_step  = pick_step();
                    c.explode2_ramp_step = pick_step();
                    c.gravity_step       = pick_step();
                    c.drag_step          = pick_step();
                end
            endcase
            program_steps(c);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 30 == 0)
                    calm = ($urandom_range(0, 2) == 0);
                if (ph == PHASES - 1)
                    calm = 1'b1;
                p = pick_particle($urandom_range(0, 9) < 7);
                send_particle(p, advance_particle(p));
                sender_pause(calm);
            end
        end

        // wind down
        drain_updates();
        if (mismatches == 0 && pending_updates.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* fixed_point_particle_update.f */
hw/rtl/fppu_pkg.sv
hw/rtl/fppu_front.sv
hw/rtl/fppu_queue.sv
hw/rtl/fppu_back.sv
hw/rtl/fixed_point_particle_update.sv
dv/testbench.sv
